@@ hw/rtl/sld_pkg.sv @@
// Shared types and constants for the sync-word length-prefixed deframer.
package sld_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned LENGTH_W = 16;

   localparam logic [LENGTH_W-1:0] MAX_PAYLOAD_RESET = 16'hFFFF;

   localparam logic [BYTE_W-1:0] SYNC_0 = 8'hEF;
   localparam logic [BYTE_W-1:0] SYNC_1 = 8'hBE;
   localparam logic [BYTE_W-1:0] SYNC_2 = 8'hEB;
   localparam logic [BYTE_W-1:0] SYNC_3 = 8'hFE;

   typedef enum logic [7:0] {
      PH_HUNT0   = 8'b0000_0001,
      PH_HUNT1   = 8'b0000_0010,
      PH_HUNT2   = 8'b0000_0100,
      PH_HUNT3   = 8'b0000_1000,
      PH_CHANNEL = 8'b0001_0000,
      PH_LEN_HI  = 8'b0010_0000,
      PH_LEN_LO  = 8'b0100_0000,
      PH_PAYLOAD = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   frame_channel;
      logic [LENGTH_W-1:0] frame_length;
      logic [BYTE_W-1:0]   payload_byte;
      logic                is_empty;
      logic                is_last;
   } result_type;

endpackage

@@ hw/rtl/sync_length_deframer_core.sv @@
// Top level of the sync-word length-prefixed deframer with result register.
//
//   channel  direction  ports
//   req      in         req_valid, req_ready, req_rx_byte
//   rsp      out        rsp_valid, rsp_ready, rsp_frame_channel .. rsp_is_last
//   csr      in         csr_valid, csr_ready, csr_max_payload
//
// One word per cycle; a result appears in the cycle after its word is taken,
// from the single result register. req_ready drops only while a result is
// held and rsp_ready is low, and during reset. Reset (synchronous) returns to
// sync hunt and sets max_payload to 65535. csr_ready is high outside reset.
module sync_length_deframer_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [sld_pkg::BYTE_W-1:0]      req_rx_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [sld_pkg::BYTE_W-1:0]      rsp_frame_channel,
   output logic [sld_pkg::LENGTH_W-1:0]    rsp_frame_length,
   output logic [sld_pkg::BYTE_W-1:0]      rsp_payload_byte,
   output logic                            rsp_is_empty,
   output logic                            rsp_is_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sld_pkg::LENGTH_W-1:0]    csr_max_payload
);

   logic [sld_pkg::LENGTH_W-1:0] max_payload_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   sld_pkg::result_type          rsp_ff;
   sld_pkg::result_type          res;
   logic                         res_valid;
   logic                         step;

   assign csr_ready = !reset;
   assign req_ready = !reset && (!rsp_valid_ff || rsp_ready);
   assign step      = req_valid && req_ready;

   sld_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .rx_byte     (req_rx_byte),
      .max_payload (max_payload_ff),
      .res_valid   (res_valid),
      .res         (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= sld_pkg::MAX_PAYLOAD_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            max_payload_ff <= csr_max_payload;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_channel = rsp_ff.frame_channel;
   assign rsp_frame_length  = rsp_ff.frame_length;
   assign rsp_payload_byte  = rsp_ff.payload_byte;
   assign rsp_is_empty      = rsp_ff.is_empty;
   assign rsp_is_last       = rsp_ff.is_last;

endmodule

@@ hw/rtl/sld_parser.sv @@
// Frame parser: sync hunt, header capture and payload counting, one word per step.
module sld_parser (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic [sld_pkg::BYTE_W-1:0]      rx_byte,
   input  logic [sld_pkg::LENGTH_W-1:0]    max_payload,
   output logic                            res_valid,
   output sld_pkg::result_type             res
);

   sld_pkg::phase_type               phase_ff, phase_in;
   logic [sld_pkg::BYTE_W-1:0]       held_channel_ff, held_channel_in;
   logic [sld_pkg::LENGTH_W-1:0]     held_length_ff, held_length_in;
   logic [sld_pkg::LENGTH_W-1:0]     bytes_left_ff, bytes_left_in;
   logic [sld_pkg::LENGTH_W-1:0]     length_full;

   assign length_full = {held_length_ff[15:8], rx_byte};

   always_comb begin
      phase_in        = phase_ff;
      held_channel_in = held_channel_ff;
      held_length_in  = held_length_ff;
      bytes_left_in   = bytes_left_ff;
      res_valid       = 1'b0;
      res.frame_channel = held_channel_ff;
      res.frame_length  = held_length_ff;
      res.payload_byte  = rx_byte;
      res.is_empty      = 1'b0;
      res.is_last       = 1'b0;
      unique case (phase_ff)
         sld_pkg::PH_HUNT0: begin
            phase_in = (rx_byte == sld_pkg::SYNC_0) ? sld_pkg::PH_HUNT1 : sld_pkg::PH_HUNT0;
         end
         sld_pkg::PH_HUNT1: begin
            phase_in = (rx_byte == sld_pkg::SYNC_1) ? sld_pkg::PH_HUNT2 : sld_pkg::PH_HUNT0;
         end
         sld_pkg::PH_HUNT2: begin
            phase_in = (rx_byte == sld_pkg::SYNC_2) ? sld_pkg::PH_HUNT3 : sld_pkg::PH_HUNT0;
         end
         sld_pkg::PH_HUNT3: begin
            phase_in = (rx_byte == sld_pkg::SYNC_3) ? sld_pkg::PH_CHANNEL : sld_pkg::PH_HUNT0;
         end
         sld_pkg::PH_CHANNEL: begin
            held_channel_in = rx_byte;
            phase_in        = sld_pkg::PH_LEN_HI;
         end
         sld_pkg::PH_LEN_HI: begin
            held_length_in = {rx_byte, 8'h00};
            phase_in       = sld_pkg::PH_LEN_LO;
         end
         sld_pkg::PH_LEN_LO: begin
            held_length_in   = length_full;
            res.frame_length = length_full;
            if (length_full > max_payload) begin
               phase_in = sld_pkg::PH_HUNT0;
            end else if (length_full == '0) begin
               phase_in         = sld_pkg::PH_HUNT0;
               res_valid        = 1'b1;
               res.payload_byte = '0;
               res.is_empty     = 1'b1;
               res.is_last      = 1'b1;
            end else begin
               bytes_left_in = length_full;
               phase_in      = sld_pkg::PH_PAYLOAD;
            end
         end
         sld_pkg::PH_PAYLOAD: begin
            res_valid = 1'b1;
            if (bytes_left_ff != '0) begin
               bytes_left_in = bytes_left_ff - 16'd1;
            end
            if (bytes_left_ff <= 16'd1) begin
               res.is_last = 1'b1;
               phase_in    = sld_pkg::PH_HUNT0;
            end
         end
         default: begin
            phase_in = sld_pkg::PH_HUNT0;
         end
      endcase
      if (!step) begin
         res_valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= sld_pkg::PH_HUNT0;
         held_channel_ff <= '0;
         held_length_ff  <= '0;
         bytes_left_ff   <= '0;
      end else if (step) begin
         phase_ff        <= phase_in;
         held_channel_ff <= held_channel_in;
         held_length_ff  <= held_length_in;
         bytes_left_ff   <= bytes_left_in;
      end
   end

endmodule
